FILE: hw/rtl/box_tilemap_collision_check_core_assert.svh
// ----------------------------------------------------------------------------
// box_tilemap_collision_check_core_assert.svh
// assertion macros for the checker file, clocked on clk, off in reset
// ----------------------------------------------------------------------------
`ifndef BOX_TILEMAP_COLLISION_CHECK_CORE_ASSERT_SVH
`define BOX_TILEMAP_COLLISION_CHECK_CORE_ASSERT_SVH

// property holds in the same cycle
`define BTCC_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define BTCC_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/btcc_pkg.sv
// ----------------------------------------------------------------------------
// btcc_pkg
// types and constants of the tile map collision check core
// ----------------------------------------------------------------------------
`default_nettype none

package btcc_pkg;

	localparam int PIX_W  = 13;
	localparam int IDX_W  = 9;
	localparam int ADDR_W = 5;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	localparam logic [2:0] REG_SIDE_MARGIN   = 3'd0;
	localparam logic [2:0] REG_OBJECT_WIDTH  = 3'd1;
	localparam logic [2:0] REG_OBJECT_HEIGHT = 3'd2;
	localparam logic [2:0] REG_MAP_COLUMNS   = 3'd3;
	localparam logic [2:0] REG_MAP_ROWS      = 3'd4;

	localparam logic [6:0] SIDE_MARGIN_RST   = 7'd0;
	localparam logic [7:0] OBJECT_WIDTH_RST  = 8'd32;
	localparam logic [7:0] OBJECT_HEIGHT_RST = 8'd32;
	localparam logic [6:0] MAP_COLUMNS_RST   = 7'd64;
	localparam logic [6:0] MAP_ROWS_RST      = 7'd64;

	typedef struct packed {
		logic        cmd;
		logic [5:0]  tile_column;
		logic [5:0]  tile_row;
		logic [15:0] tile_id;
		logic [11:0] pos_x;
		logic [11:0] pos_y;
	} item_t;

	typedef struct packed {
		logic hit;
		logic status;
	} result_t;

	typedef struct packed {
		logic [6:0] side_margin;
		logic [7:0] object_width;
		logic [7:0] object_height;
		logic [6:0] map_columns;
		logic [6:0] map_rows;
	} cfg_t;

	typedef enum logic [1:0] {
		DIV_XL = 2'd0,
		DIV_XR = 2'd1,
		DIV_YT = 2'd2,
		DIV_YB = 2'd3
	} div_sel_t;

	typedef struct packed {
		logic     capture;
		logic     wr_read;
		logic     wr_write;
		logic     div_en;
		div_sel_t div_sel;
		logic     setup;
		logic     row_read;
		logic     finish;
	} dp_cmd_t;

	typedef struct packed {
		logic start_query;
		logic scan_none;
		logic row_last;
	} dp_sts_t;

endpackage

`default_nettype wire

FILE: hw/rtl/box_tilemap_collision_check_core.sv
// ----------------------------------------------------------------------------
// box_tilemap_collision_check_core
// tile map of solid flags with axis-aligned box collision queries
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; its result shows for
// exactly one cycle with done, and busy drops in that same cycle, so the next
// start may be taken while done is up. A tile write goes from accept to done
// through a row read, a merged row write and the result register. In a query
// the left, right, top and bottom box edges go one after another through the
// one shared reciprocal multiplier for the corner tile indexes, then come a
// setup step, a scan of one row per cycle on the map's single row-wide read
// port over the n map rows the box covers inside the map (0 when the box is
// empty or lies wholly off the map), a step to collect the last row and the
// result register. The map is empty right after reset with no clearing pass.
// The result must be taken when done is high; it is not held.
// ----------------------------------------------------------------------------
`default_nettype none

module box_tilemap_collision_check_core #(
	parameter int MAX_COLUMNS = 64,
	parameter int MAX_ROWS    = 64,
	parameter int TILE_PIXELS = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  btcc_pkg::item_t             item,
	output logic                        done,
	output btcc_pkg::result_t           result,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [btcc_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);
	import btcc_pkg::*;

	cfg_t    cfg;
	dp_cmd_t dp_cmd;
	dp_sts_t dp_sts;

	btcc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	btcc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (dp_sts),
		.cmd    (dp_cmd),
		.busy   (busy)
	);

	btcc_datapath #(
		.MAX_COLUMNS (MAX_COLUMNS),
		.MAX_ROWS    (MAX_ROWS),
		.TILE_PIXELS (TILE_PIXELS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cfg    (cfg),
		.cmd    (dp_cmd),
		.sts    (dp_sts),
		.done   (done),
		.result (result)
	);

endmodule

`default_nettype wire

FILE: hw/rtl/btcc_regs.sv
// ----------------------------------------------------------------------------
// btcc_regs
// apb configuration registers: margin, object size and map size
// ----------------------------------------------------------------------------
`default_nettype none

module btcc_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [btcc_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	output btcc_pkg::cfg_t              cfg
);
	import btcc_pkg::*;

	cfg_t       cfg_q;
	logic [2:0] reg_idx;
	logic       wr_en;

	assign reg_idx = paddr[ADDR_W-1:2];
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.side_margin   <= SIDE_MARGIN_RST;
			cfg_q.object_width  <= OBJECT_WIDTH_RST;
			cfg_q.object_height <= OBJECT_HEIGHT_RST;
			cfg_q.map_columns   <= MAP_COLUMNS_RST;
			cfg_q.map_rows      <= MAP_ROWS_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_SIDE_MARGIN:   cfg_q.side_margin   <= pwdata[6:0];
				REG_OBJECT_WIDTH:  cfg_q.object_width  <= pwdata[7:0];
				REG_OBJECT_HEIGHT: cfg_q.object_height <= pwdata[7:0];
				REG_MAP_COLUMNS:   cfg_q.map_columns   <= pwdata[6:0];
				REG_MAP_ROWS:      cfg_q.map_rows      <= pwdata[6:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_SIDE_MARGIN:   prdata = 32'(cfg_q.side_margin);
			REG_OBJECT_WIDTH:  prdata = 32'(cfg_q.object_width);
			REG_OBJECT_HEIGHT: prdata = 32'(cfg_q.object_height);
			REG_MAP_COLUMNS:   prdata = 32'(cfg_q.map_columns);
			REG_MAP_ROWS:      prdata = 32'(cfg_q.map_rows);
			default:           prdata = 32'd0;
		endcase
	end

endmodule

`default_nettype wire

FILE: hw/rtl/btcc_ctrl.sv
// ----------------------------------------------------------------------------
// btcc_ctrl
// sequencer: tile write read-modify-write, corner division, row scan
// ----------------------------------------------------------------------------
`default_nettype none

module btcc_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  btcc_pkg::dp_sts_t  sts,
	output btcc_pkg::dp_cmd_t  cmd,
	output logic               busy
);
	import btcc_pkg::*;

	typedef enum logic [9:0] {
		S_IDLE   = 10'b00_0000_0001,
		S_WR_RD  = 10'b00_0000_0010,
		S_WR_WR  = 10'b00_0000_0100,
		S_DIV_XL = 10'b00_0000_1000,
		S_DIV_XR = 10'b00_0001_0000,
		S_DIV_YT = 10'b00_0010_0000,
		S_DIV_YB = 10'b00_0100_0000,
		S_SETUP  = 10'b00_1000_0000,
		S_SCAN   = 10'b01_0000_0000,
		S_FLUSH  = 10'b10_0000_0000
	} state_t;

	state_t state_q;
	state_t state_nxt;

	assign busy = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.capture = 1'b1;
					state_nxt   = sts.start_query ? S_DIV_XL : S_WR_RD;
				end
			end
			S_WR_RD: begin
				cmd.wr_read = 1'b1;
				state_nxt   = S_WR_WR;
			end
			S_WR_WR: begin
				cmd.wr_write = 1'b1;
				cmd.finish   = 1'b1;
				state_nxt    = S_IDLE;
			end
			S_DIV_XL: begin
				cmd.div_en  = 1'b1;
				cmd.div_sel = DIV_XL;
				state_nxt   = S_DIV_XR;
			end
			S_DIV_XR: begin
				cmd.div_en  = 1'b1;
				cmd.div_sel = DIV_XR;
				state_nxt   = S_DIV_YT;
			end
			S_DIV_YT: begin
				cmd.div_en  = 1'b1;
				cmd.div_sel = DIV_YT;
				state_nxt   = S_DIV_YB;
			end
			S_DIV_YB: begin
				cmd.div_en  = 1'b1;
				cmd.div_sel = DIV_YB;
				state_nxt   = S_SETUP;
			end
			S_SETUP: begin
				cmd.setup = 1'b1;
				state_nxt = sts.scan_none ? S_FLUSH : S_SCAN;
			end
			S_SCAN: begin
				cmd.row_read = 1'b1;
				if (sts.row_last) begin
					state_nxt = S_FLUSH;
				end
			end
			S_FLUSH: begin
				cmd.finish = 1'b1;
				state_nxt  = S_IDLE;
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

FILE: hw/rtl/btcc_datapath.sv
// ----------------------------------------------------------------------------
// btcc_datapath
// item registers, reciprocal divider, row-wide tile map and hit reduction
// ----------------------------------------------------------------------------
`default_nettype none

module btcc_datapath #(
	parameter int MAX_COLUMNS = 64,
	parameter int MAX_ROWS    = 64,
	parameter int TILE_PIXELS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  btcc_pkg::item_t    item,
	input  btcc_pkg::cfg_t     cfg,
	input  btcc_pkg::dp_cmd_t  cmd,
	output btcc_pkg::dp_sts_t  sts,
	output logic               done,
	output btcc_pkg::result_t  result
);
	import btcc_pkg::*;

	localparam int RAW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int DIV_L  = $clog2(TILE_PIXELS);
	localparam int DIV_S  = PIX_W + DIV_L;
	localparam int MUL_W  = PIX_W + 1;
	localparam int PROD_W = PIX_W + MUL_W;
	localparam int DIV_M  = ((1 << DIV_S) + TILE_PIXELS - 1) / TILE_PIXELS;
	localparam logic [MUL_W-1:0] RECIP = MUL_W'(DIV_M);

	// captured item
	logic             is_query_q;
	logic [5:0]       col_q;
	logic [5:0]       row_q;
	logic             solid_q;
	logic             wr_ok_q;
	logic             empty_q;
	logic [PIX_W-1:0] xl_q;
	logic [PIX_W-1:0] xr_q;
	logic [PIX_W-1:0] yt_q;
	logic [PIX_W-1:0] yb_q;

	// tile indexes
	logic [PIX_W-1:0]  div_opnd;
	logic [PROD_W-1:0] prod;
	logic [PIX_W-1:0]  quot;
	logic [PIX_W-1:0]  c0_q;
	logic [PIX_W-1:0]  c1_q;
	logic [PIX_W-1:0]  r0_q;
	logic [PIX_W-1:0]  r1_q;

	// scan setup
	logic [IDX_W-1:0]       cols_lim;
	logic [IDX_W-1:0]       rows_lim;
	logic [PIX_W-1:0]       cols_w;
	logic [PIX_W-1:0]       rows_w;
	logic                   c_over;
	logic                   r_over;
	logic [PIX_W-1:0]       c1e;
	logic [PIX_W-1:0]       r1e;
	logic [MAX_COLUMNS-1:0] colmask;
	logic                   scan_none;
	logic [MAX_COLUMNS-1:0] colmask_q;
	logic                   status_q;
	logic [PIX_W-1:0]       r_q;
	logic [PIX_W-1:0]       r_end_q;

	// map storage
	logic [MAX_COLUMNS-1:0] map_mem [MAX_ROWS];
	logic [MAX_ROWS-1:0]    row_vld_q;
	logic [IDX_W-1:0]       wr_row_ext;
	logic [RAW-1:0]         wr_addr;
	logic [RAW-1:0]         rd_addr;
	logic                   mem_re;
	logic                   mem_we;
	logic [MAX_COLUMNS-1:0] merged;
	logic [MAX_COLUMNS-1:0] rd_data_s1;
	logic                   rd_vld_s1;
	logic                   chk_s1;
	logic                   chk_hit;
	logic                   hit_q;

	logic    done_q;
	result_t result_q;

	assign sts.start_query = (item.cmd == CMD_QUERY);
	assign sts.scan_none   = scan_none;
	assign sts.row_last    = (r_q == r_end_q);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			is_query_q <= (item.cmd == CMD_QUERY);
			col_q      <= item.tile_column;
			row_q      <= item.tile_row;
			solid_q    <= (item.tile_id != 16'd0);
			wr_ok_q    <= (IDX_W'(item.tile_column) < IDX_W'(MAX_COLUMNS))
				&& (IDX_W'(item.tile_row) < IDX_W'(MAX_ROWS));
			empty_q    <= (cfg.object_width < {cfg.side_margin, 1'b0});
			xl_q       <= PIX_W'(item.pos_x) + PIX_W'(cfg.side_margin);
			xr_q       <= PIX_W'(item.pos_x) + PIX_W'(cfg.object_width)
				- PIX_W'(cfg.side_margin);
			yt_q       <= PIX_W'(item.pos_y);
			yb_q       <= PIX_W'(item.pos_y) + PIX_W'(cfg.object_height);
		end
	end

	// shared reciprocal multiplier, exact for all PIX_W-bit operands
	always_comb begin
		unique case (cmd.div_sel)
			DIV_XL:  div_opnd = xl_q;
			DIV_XR:  div_opnd = xr_q;
			DIV_YT:  div_opnd = yt_q;
			DIV_YB:  div_opnd = yb_q;
			default: div_opnd = xl_q;
		endcase
	end

	assign prod = PROD_W'(div_opnd) * PROD_W'(RECIP);
	assign quot = PIX_W'(prod >> DIV_S);

	always_ff @(posedge clk) begin
		if (cmd.div_en) begin
			unique case (cmd.div_sel)
				DIV_XL:  c0_q <= quot;
				DIV_XR:  c1_q <= quot;
				DIV_YT:  r0_q <= quot;
				DIV_YB:  r1_q <= quot;
				default: ;
			endcase
		end
	end

	assign cols_lim = (IDX_W'(cfg.map_columns) > IDX_W'(MAX_COLUMNS))
		? IDX_W'(MAX_COLUMNS) : IDX_W'(cfg.map_columns);
	assign rows_lim = (IDX_W'(cfg.map_rows) > IDX_W'(MAX_ROWS))
		? IDX_W'(MAX_ROWS) : IDX_W'(cfg.map_rows);
	assign cols_w   = PIX_W'(cols_lim);
	assign rows_w   = PIX_W'(rows_lim);
	assign c_over   = (c1_q >= cols_w);
	assign r_over   = (r1_q >= rows_w);
	assign c1e      = c_over ? (cols_w - PIX_W'(1)) : c1_q;
	assign r1e      = r_over ? (rows_w - PIX_W'(1)) : r1_q;
	assign scan_none = empty_q || (cols_lim == '0) || (rows_lim == '0)
		|| (c0_q > c1e) || (r0_q > r1e);

	always_comb begin
		for (int i = 0; i < MAX_COLUMNS; i++) begin
			colmask[i] = (PIX_W'(i) >= c0_q) && (PIX_W'(i) <= c1e);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.setup) begin
			colmask_q <= colmask;
			status_q  <= !empty_q && (c_over || r_over);
			r_end_q   <= r1e;
		end
		if (cmd.setup) begin
			r_q <= r0_q;
		end else if (cmd.row_read) begin
			r_q <= r_q + PIX_W'(1);
		end
	end

	// row-wide map, one row read per cycle, writes by read-modify-write
	assign wr_row_ext = IDX_W'(row_q);
	assign wr_addr    = wr_row_ext[RAW-1:0];
	assign rd_addr    = cmd.wr_read ? wr_addr : r_q[RAW-1:0];
	assign mem_re     = cmd.wr_read || cmd.row_read;
	assign mem_we     = cmd.wr_write && wr_ok_q;

	always_comb begin
		merged = rd_vld_s1 ? rd_data_s1 : '0;
		for (int i = 0; i < MAX_COLUMNS; i++) begin
			if (IDX_W'(i) == IDX_W'(col_q)) begin
				merged[i] = solid_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			map_mem[wr_addr] <= merged;
		end
		if (mem_re) begin
			rd_data_s1 <= map_mem[rd_addr];
			rd_vld_s1  <= row_vld_q[rd_addr];
		end
	end

	// rows never written read as empty
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
		end else if (mem_we) begin
			row_vld_q[wr_addr] <= 1'b1;
		end
	end

	assign chk_hit = chk_s1 && rd_vld_s1 && (|(rd_data_s1 & colmask_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chk_s1 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			chk_s1 <= cmd.row_read;
			done_q <= cmd.finish;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			hit_q <= 1'b0;
		end else if (chk_hit) begin
			hit_q <= 1'b1;
		end
		if (cmd.finish) begin
			result_q.hit    <= is_query_q && (hit_q || chk_hit);
			result_q.status <= is_query_q ? status_q : !wr_ok_q;
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

`default_nettype wire

FILE: hw/rtl/btcc_checker.sv
// ----------------------------------------------------------------------------
// btcc_checker
// port-level checks of the collision core, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "box_tilemap_collision_check_core_assert.svh"

module btcc_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input logic pready
);

	`BTCC_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "no busy after accepted beat")
	`BTCC_ASSERT_NEXT(a_done_single, done, !done, "done held longer than one cycle")
	`BTCC_ASSERT(a_done_idle, !done || !busy, "done while still busy")
	`BTCC_ASSERT(a_done_after_busy, !done || $past(busy), "done without work in progress")
	`BTCC_ASSERT(a_pready_high, pready, "pready low")

endmodule

bind box_tilemap_collision_check_core btcc_checker u_btcc_checker (.*);

`default_nettype wire
